// File: sv/mbpus_pkg.sv
// ============================================================================
// mbpus_pkg - shared types and constants for the masked byte pattern search
// Holds the register index codes, result status codes, byte lane constants
// and the control bundle that the top level hands to every compare cell.
// ============================================================================
package mbpus_pkg;

    // Pattern bytes held in the configuration registers (two 64-bit words)
    localparam int CFG_LANES      = 16;
    localparam int LANES_PER_WORD = 8;
    localparam int CFG_DATA_W     = 64;
    localparam int LEN_W          = 5;
    localparam int CFG_INDEX_W    = 3;

    // Mask byte codes
    localparam logic [7:0] MASK_COMPARE = 8'hFF;
    localparam logic [7:0] MASK_IGNORE  = 8'h00;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PAT_LO  = 3'd0,
        CFG_PAT_HI  = 3'd1,
        CFG_MASK_LO = 3'd2,
        CFG_MASK_HI = 3'd3,
        CFG_LEN     = 3'd4
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        ST_UNIQUE    = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_AMBIGUOUS = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    // Per-beat control for the compare cells
    typedef struct packed {
        logic advance;  // a beat is taken this cycle
        logic clear;    // the beat closes the haystack
    } t_cell_ctl;

endpackage

// File: sv/mbpus_cell.sv
// ============================================================================
// mbpus_cell - one pattern position of the compare chain
// Holds a single prefix-match bit: pattern bytes 0..k matched ending on the
// previous beat. The bit of the left neighbor extends by one byte each beat.
// ============================================================================
module mbpus_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mbpus_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]           i_data_byte,
    input  logic [7:0]           i_pat_byte,
    input  logic [7:0]           i_mask_byte,
    input  logic                 i_prefix,
    output logic                 o_match_next,
    output logic                 o_match
);

    logic r_match;
    logic n_match;

    // Extend the neighbor's prefix by the current beat
    always_comb begin
        n_match = i_prefix &&
                  ((i_mask_byte != mbpus_pkg::MASK_COMPARE) || (i_data_byte == i_pat_byte));
    end

    // Hold the prefix bit; drop it at the end of a haystack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.advance) begin
            r_match <= i_ctl.clear ? 1'b0 : n_match;
        end
    end

    assign o_match_next = n_match;
    assign o_match      = r_match;

endmodule

// File: sv/mbpus_check.sv
// ============================================================================
// mbpus_check - pattern validity check
// A pattern is usable when its length is in range, every in-use mask byte is
// 00 or FF, and at least one in-use mask byte is FF.
// ============================================================================
module mbpus_check #(
    parameter int PATTERN_MAX = 16
) (
    input  logic [7:0]                  i_mask [PATTERN_MAX],
    input  logic [mbpus_pkg::LEN_W-1:0] i_len,
    output logic                        o_valid
);

    logic w_bad;
    logic w_any;

    // Scan the in-use mask bytes
    always_comb begin
        w_bad = 1'b0;
        w_any = 1'b0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if (j < int'(i_len)) begin
                if ((i_mask[j] != mbpus_pkg::MASK_COMPARE) &&
                    (i_mask[j] != mbpus_pkg::MASK_IGNORE)) begin
                    w_bad = 1'b1;
                end
                if (i_mask[j] == mbpus_pkg::MASK_COMPARE) begin
                    w_any = 1'b1;
                end
            end
        end
    end

    assign o_valid = (i_len != '0) && (int'(i_len) <= PATTERN_MAX) && !w_bad && w_any;

endmodule

// File: sv/masked_byte_pattern_unique_search.sv
// ============================================================================
// masked_byte_pattern_unique_search - streaming masked byte pattern search
// Scans a haystack one byte per beat for a masked pattern and reports one
// result beat per haystack: unique match, not found, ambiguous or invalid.
// ============================================================================
// Usage:
//   Input channel (i_valid / o_stall) carries one haystack byte per beat;
//   i_last marks the final byte. Output channel (o_valid / i_stall) carries
//   one result beat per haystack, issued only for a beat with i_last set.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data
//   while no haystack is in flight.
//   Throughput: one byte per cycle. A row of PATTERN_MAX compare cells holds
//   prefix-match bits that advance one position per beat, so every alignment
//   ending on the current byte is resolved in the cycle it arrives.
//   Output: the result appears on o_valid in the cycle after the last byte
//   is taken, from a single output register.
//   Stall: while the output register is full and i_stall is high, o_stall is
//   raised and no byte is taken; otherwise bytes flow on every cycle.
//   Reset: configuration registers return to zero, the pattern reads as
//   invalid, the stream counters clear and the output register is empty.
//   Counters clear again after every last byte.
// ============================================================================
module masked_byte_pattern_unique_search #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [mbpus_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mbpus_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // haystack channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic [OFFSET_BITS-1:0]            o_lead_offset,
    output logic [OFFSET_BITS-1:0]            o_hit_total
);

    localparam logic [OFFSET_BITS-1:0] OfsMax = '1;

    // Configuration registers
    logic [mbpus_pkg::CFG_DATA_W-1:0] r_pat_lo;
    logic [mbpus_pkg::CFG_DATA_W-1:0] r_pat_hi;
    logic [mbpus_pkg::CFG_DATA_W-1:0] r_mask_lo;
    logic [mbpus_pkg::CFG_DATA_W-1:0] r_mask_hi;
    logic [mbpus_pkg::LEN_W-1:0]      r_len;

    // Stream state
    logic [OFFSET_BITS-1:0] r_seen;
    logic [OFFSET_BITS-1:0] r_first;
    logic [OFFSET_BITS-1:0] r_count;
    logic [OFFSET_BITS-1:0] n_seen;
    logic [OFFSET_BITS-1:0] n_first;
    logic [OFFSET_BITS-1:0] n_count;

    // Output register
    logic                   r_out_valid;
    mbpus_pkg::t_status     r_status;
    logic [OFFSET_BITS-1:0] r_out_first;
    logic [OFFSET_BITS-1:0] r_out_count;
    mbpus_pkg::t_status     n_status;
    logic [OFFSET_BITS-1:0] n_out_first;
    logic [OFFSET_BITS-1:0] n_out_count;

    logic                 w_in_take;
    logic                 w_out_take;
    logic                 w_pat_valid;
    logic                 w_hit;
    logic [OFFSET_BITS-1:0] w_len_ext;
    mbpus_pkg::t_cell_ctl w_ctl;

    logic [7:0] w_pat  [PATTERN_MAX];
    logic [7:0] w_mask [PATTERN_MAX];
    logic       w_prefix     [PATTERN_MAX];
    logic       w_match_next [PATTERN_MAX];
    logic       w_match      [PATTERN_MAX];

    // Handshake
    assign o_stall    = r_out_valid && i_stall;
    assign w_in_take  = i_valid && !o_stall;
    assign w_out_take = r_out_valid && !i_stall;
    assign w_ctl.advance = w_in_take;
    assign w_ctl.clear   = w_in_take && i_last;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_mask_lo <= '0;
            r_mask_hi <= '0;
            r_len     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mbpus_pkg::CFG_PAT_LO:  r_pat_lo  <= i_cfg_data;
                mbpus_pkg::CFG_PAT_HI:  r_pat_hi  <= i_cfg_data;
                mbpus_pkg::CFG_MASK_LO: r_mask_lo <= i_cfg_data;
                mbpus_pkg::CFG_MASK_HI: r_mask_hi <= i_cfg_data;
                mbpus_pkg::CFG_LEN:     r_len     <= i_cfg_data[mbpus_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Split the registers into byte lanes and build the cell chain
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        if (j < mbpus_pkg::LANES_PER_WORD) begin : g_lo
            assign w_pat[j]  = r_pat_lo[8*j +: 8];
            assign w_mask[j] = r_mask_lo[8*j +: 8];
        end else if (j < mbpus_pkg::CFG_LANES) begin : g_hi
            assign w_pat[j]  = r_pat_hi[8*(j-mbpus_pkg::LANES_PER_WORD) +: 8];
            assign w_mask[j] = r_mask_hi[8*(j-mbpus_pkg::LANES_PER_WORD) +: 8];
        end else begin : g_none
            assign w_pat[j]  = 8'h00;
            assign w_mask[j] = mbpus_pkg::MASK_IGNORE;
        end

        if (j == 0) begin : g_head
            assign w_prefix[j] = 1'b1;
        end else begin : g_link
            assign w_prefix[j] = w_match[j-1];
        end

        mbpus_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_data_byte  (i_data_byte),
            .i_pat_byte   (w_pat[j]),
            .i_mask_byte  (w_mask[j]),
            .i_prefix     (w_prefix[j]),
            .o_match_next (w_match_next[j]),
            .o_match      (w_match[j])
        );
    end

    mbpus_check #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_check (
        .i_mask  (w_mask),
        .i_len   (r_len),
        .o_valid (w_pat_valid)
    );

    // Tap the cell whose position closes the pattern
    always_comb begin
        w_hit = 1'b0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            if ((int'(r_len) == j + 1) && w_match_next[j]) begin
                w_hit = 1'b1;
            end
        end
        w_hit = w_hit && w_pat_valid;
    end

    assign w_len_ext = OFFSET_BITS'(r_len);

    // Advance the byte counter, first offset and match count
    always_comb begin
        n_seen  = (r_seen == OfsMax) ? r_seen : r_seen + OFFSET_BITS'(1);
        n_first = r_first;
        n_count = r_count;
        if (w_hit) begin
            if (r_count == '0) begin
                n_first = r_seen - (w_len_ext - OFFSET_BITS'(1));
            end
            if (r_count != OfsMax) begin
                n_count = r_count + OFFSET_BITS'(1);
            end
        end
    end

    // Form the result for a last beat
    always_comb begin
        n_out_first = '0;
        n_out_count = '0;
        priority if (!w_pat_valid) begin
            n_status = mbpus_pkg::ST_INVALID;
        end else if (n_count == '0) begin
            n_status = mbpus_pkg::ST_NOT_FOUND;
        end else if (n_count == OFFSET_BITS'(1)) begin
            n_status    = mbpus_pkg::ST_UNIQUE;
            n_out_first = n_first;
            n_out_count = n_count;
        end else begin
            n_status    = mbpus_pkg::ST_AMBIGUOUS;
            n_out_first = n_first;
            n_out_count = n_count;
        end
    end

    // Hold stream counters; clear them after a last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_first <= '0;
            r_count <= '0;
        end else if (w_in_take) begin
            if (i_last) begin
                r_seen  <= '0;
                r_first <= '0;
                r_count <= '0;
            end else begin
                r_seen  <= n_seen;
                r_first <= n_first;
                r_count <= n_count;
            end
        end
    end

    // Output register: load on a last beat, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.clear) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.clear) begin
            r_status    <= n_status;
            r_out_first <= n_out_first;
            r_out_count <= n_out_count;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_lead_offset = r_out_first;
    assign o_hit_total   = r_out_count;

    // Checks
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last) |=> o_valid)
        else $error("last beat taken without a result beat");

    a_counters_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last) |=> (r_seen == '0 && r_count == '0 && r_first == '0))
        else $error("stream counters not cleared after last beat");

    a_unique_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == mbpus_pkg::ST_UNIQUE) |-> (o_hit_total == OFFSET_BITS'(1)))
        else $error("unique match with count other than one");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_status == mbpus_pkg::ST_NOT_FOUND || r_status == mbpus_pkg::ST_INVALID))
        |-> (o_lead_offset == '0 && o_hit_total == '0))
        else $error("no-match result carries offset or count");

endmodule

// File: dv/tb_masked_byte_pattern_unique_search.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_masked_byte_pattern_unique_search - self-checking bench for the search
// Feeds haystacks byte by byte, predicts each result beat from a local model
// of the window, counters and registers, and compares every result field.
// A directed table covers the reset state, the extremes and the invalid
// patterns. Random phases then load new pattern settings and stream haystacks
// built around the pattern, with random input gaps and result-side stalls.
// ============================================================================
module tb_masked_byte_pattern_unique_search;

    localparam int          OFS_W       = 24;
    localparam logic [23:0] OFS_SAT     = '1;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          RAND_BEATS  = 1000;

    typedef struct packed {
        mbpus_pkg::t_status status;
        logic [OFS_W-1:0]   lead_offset;
        logic [OFS_W-1:0]   hit_total;
    } t_scan_result;

    // One row of the directed table: a pattern setting or a haystack beat
    typedef struct packed {
        bit           is_setting;
        logic [63:0]  pl;
        logic [63:0]  ph;
        logic [63:0]  ml;
        logic [63:0]  mh;
        logic [4:0]   len;
        logic [7:0]   data;
        bit           last;
        bit           typed;
        t_scan_result want;
    } t_dir_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_cfg_we;
    logic [mbpus_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [mbpus_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                              i_valid;
    logic                              o_stall;
    logic [7:0]                        i_data_byte;
    logic                              i_last;
    logic                              o_valid;
    logic                              i_stall;
    logic [1:0]                        o_status;
    logic [OFS_W-1:0]                  o_lead_offset;
    logic [OFS_W-1:0]                  o_hit_total;

    masked_byte_pattern_unique_search #(
        .PATTERN_MAX(mbpus_pkg::CFG_LANES),
        .OFFSET_BITS(OFS_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_lead_offset (o_lead_offset),
        .o_hit_total   (o_hit_total)
    );

    // Search model: registers and stream state
    logic [7:0]       pat_lane  [mbpus_pkg::CFG_LANES];
    logic [7:0]       mask_lane [mbpus_pkg::CFG_LANES];
    logic [4:0]       pat_len;
    logic [7:0]       hist [mbpus_pkg::CFG_LANES-1];  // [0] = byte just before the current one
    logic [OFS_W-1:0] seen_cnt;
    logic [OFS_W-1:0] first_hit;
    logic [OFS_W-1:0] hit_cnt;

    t_scan_result result_q[$];
    t_dir_row     dir_rows[$];

    int err_count;
    int beats_sent;
    int hays_sent;
    int settings_loaded;
    int status_seen [4];
    int gap_pct;
    int stall_pct;
    int stall_left;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_scan_result make_result(mbpus_pkg::t_status st,
                                                 logic [OFS_W-1:0] ofs,
                                                 logic [OFS_W-1:0] cnt);
        t_scan_result r;
        r.status      = st;
        r.lead_offset = ofs;
        r.hit_total   = cnt;
        return r;
    endfunction

    function automatic t_dir_row beat_row(logic [7:0] d, bit l, bit typed,
                                          t_scan_result want);
        t_dir_row r;
        r            = '0;
        r.data       = d;
        r.last       = l;
        r.typed      = typed;
        r.want       = want;
        return r;
    endfunction

    function automatic t_dir_row set_row(logic [63:0] pl, logic [63:0] ph, logic [63:0] ml,
                                         logic [63:0] mh, logic [4:0] len);
        t_dir_row r;
        r            = '0;
        r.is_setting = 1'b1;
        r.pl         = pl;
        r.ph         = ph;
        r.ml         = ml;
        r.mh         = mh;
        r.len        = len;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Mirror one register write into the model
    task automatic apply_reg(input mbpus_pkg::t_cfg_idx idx, input logic [63:0] val);
        for (int i = 0; i < mbpus_pkg::LANES_PER_WORD; i++) begin
            case (idx)
                mbpus_pkg::CFG_PAT_LO:  pat_lane[i] = val[8*i +: 8];
                mbpus_pkg::CFG_PAT_HI:  pat_lane[mbpus_pkg::LANES_PER_WORD + i] = val[8*i +: 8];
                mbpus_pkg::CFG_MASK_LO: mask_lane[i] = val[8*i +: 8];
                mbpus_pkg::CFG_MASK_HI: mask_lane[mbpus_pkg::LANES_PER_WORD + i] = val[8*i +: 8];
                default: ;
            endcase
        end
        if (idx == mbpus_pkg::CFG_LEN) begin
            pat_len = val[mbpus_pkg::LEN_W-1:0];
        end
    endtask

    function automatic bit pattern_ok();
        bit any;
        any = 1'b0;
        if (pat_len == 0 || pat_len > mbpus_pkg::CFG_LANES) return 1'b0;
        for (int i = 0; i < pat_len; i++) begin
            if (mask_lane[i] != mbpus_pkg::MASK_COMPARE &&
                mask_lane[i] != mbpus_pkg::MASK_IGNORE) return 1'b0;
            if (mask_lane[i] == mbpus_pkg::MASK_COMPARE) any = 1'b1;
        end
        return any;
    endfunction

    // Advance the model by one haystack byte; a last byte yields a result
    task automatic scan_byte(input logic [7:0] b, input bit lst, output bit has_res,
                             output t_scan_result res);
        bit         ok;
        bit         hit;
        int         k;
        logic [7:0] h;
        ok      = pattern_ok();
        has_res = 1'b0;
        res     = '0;
        if (ok && int'(seen_cnt) >= int'(pat_len) - 1) begin
            hit = 1'b1;
            for (int i = 0; i < pat_len; i++) begin
                k = int'(pat_len) - 2 - i;
                h = (k < 0) ? b : hist[k];
                if (mask_lane[i] == mbpus_pkg::MASK_COMPARE && h != pat_lane[i]) hit = 1'b0;
            end
            if (hit) begin
                if (hit_cnt == 0) first_hit = seen_cnt - OFS_W'(pat_len) + 1'b1;
                if (hit_cnt != OFS_SAT) hit_cnt++;
            end
        end
        for (int i = mbpus_pkg::CFG_LANES - 2; i > 0; i--) begin
            hist[i] = hist[i-1];
        end
        hist[0] = b;
        if (seen_cnt != OFS_SAT) seen_cnt++;
        if (lst) begin
            has_res = 1'b1;
            if (!ok) begin
                res = make_result(mbpus_pkg::ST_INVALID, '0, '0);
            end else if (hit_cnt == 0) begin
                res = make_result(mbpus_pkg::ST_NOT_FOUND, '0, '0);
            end else if (hit_cnt == 1) begin
                res = make_result(mbpus_pkg::ST_UNIQUE, first_hit, OFS_W'(1));
            end else begin
                res = make_result(mbpus_pkg::ST_AMBIGUOUS, first_hit, hit_cnt);
            end
            foreach (hist[i]) hist[i] = 8'h00;
            seen_cnt  = '0;
            first_hit = '0;
            hit_cnt   = '0;
        end
    endtask

    // Hand one byte over and predict what it causes
    task automatic send_beat(input logic [7:0] b, input bit lst, input bit typed,
                             input t_scan_result typed_res);
        bit           has_res;
        t_scan_result pred;
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= lst;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scan_byte(b, lst, has_res, pred);
        if (has_res) begin
            result_q.push_back(typed ? typed_res : pred);
            hays_sent++;
        end
        beats_sent++;
    endtask

    // Hold the input off until every pending result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(input mbpus_pkg::t_cfg_idx idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    task automatic load_setting(input logic [63:0] pl, input logic [63:0] ph,
                                input logic [63:0] ml, input logic [63:0] mh,
                                input logic [4:0] len);
        put_reg(mbpus_pkg::CFG_PAT_LO, pl);
        put_reg(mbpus_pkg::CFG_PAT_HI, ph);
        put_reg(mbpus_pkg::CFG_MASK_LO, ml);
        put_reg(mbpus_pkg::CFG_MASK_HI, mh);
        put_reg(mbpus_pkg::CFG_LEN, 64'(len));
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Result side stalls in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            i_stall    <= 1'b1;
            stall_left = $urandom_range(0, 13);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_scan_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            status_seen[o_status]++;
            if (result_q.size() == 0) begin
                report_mismatch("result beat with nothing pending, status", o_status, 0);
            end else begin
                want = result_q.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_lead_offset != want.lead_offset)
                    report_mismatch("lead offset", o_lead_offset, want.lead_offset);
                if (o_hit_total != want.hit_total)
                    report_mismatch("hit total", o_hit_total, want.hit_total);
            end
        end
    end

    // Drop the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("tb_masked_byte_pattern_unique_search NOT OK");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [7:0]   plane [mbpus_pkg::CFG_LANES];
        logic [7:0]   mlane [mbpus_pkg::CFG_LANES];
        logic [63:0]  pl, ph, ml, mh;
        logic [4:0]   len;
        logic [7:0]   hay[$];
        t_scan_result no_res;
        int           rand_start;
        int           phase_bytes;
        int           nseg;
        int           pos;
        int           mode;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= mbpus_pkg::CFG_PAT_LO;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_data_byte <= 8'h00;
        i_last      <= 1'b0;
        i_stall     <= 1'b0;
        err_count   = 0;
        beats_sent  = 0;
        hays_sent   = 0;
        settings_loaded = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        gap_pct      = 0;
        stall_pct    = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        no_res       = '0;

        // Model reset state
        foreach (pat_lane[i]) pat_lane[i] = 8'h00;
        foreach (mask_lane[i]) mask_lane[i] = mbpus_pkg::MASK_IGNORE;
        foreach (hist[i]) hist[i] = 8'h00;
        pat_len   = '0;
        seen_cnt  = '0;
        first_hit = '0;
        hit_cnt   = '0;

        // Directed table
        // reset registers: zero length reads as an invalid pattern
        dir_rows.push_back(beat_row(8'h00, 1, 1,
                                    make_result(mbpus_pkg::ST_INVALID, '0, '0)));
        // two-byte pattern seen twice, then a haystack shorter than the pattern
        dir_rows.push_back(set_row(64'h0000_0000_0000_BBAA, '0, 64'h0000_0000_0000_FFFF,
                                   '0, 5'd2));
        dir_rows.push_back(beat_row(8'hAA, 0, 0, no_res));
        dir_rows.push_back(beat_row(8'hBB, 0, 0, no_res));
        dir_rows.push_back(beat_row(8'hAA, 0, 0, no_res));
        dir_rows.push_back(beat_row(8'hBB, 1, 1,
                                    make_result(mbpus_pkg::ST_AMBIGUOUS, '0, OFS_W'(2))));
        dir_rows.push_back(beat_row(8'hAA, 1, 1,
                                    make_result(mbpus_pkg::ST_NOT_FOUND, '0, '0)));
        // in-use mask byte neither ignore nor compare
        dir_rows.push_back(set_row(64'h0000_0000_0000_BBAA, '0, 64'h0000_0000_0000_7FFF,
                                   '0, 5'd2));
        dir_rows.push_back(beat_row(8'hBB, 1, 1,
                                    make_result(mbpus_pkg::ST_INVALID, '0, '0)));
        // no byte compared at all
        dir_rows.push_back(set_row(64'h0000_0000_0000_BBAA, '0, '0, '0, 5'd2));
        dir_rows.push_back(beat_row(8'hAA, 1, 1,
                                    make_result(mbpus_pkg::ST_INVALID, '0, '0)));
        // full sixteen-byte pattern of all ones, fully compared
        dir_rows.push_back(set_row('1, '1, '1, '1, 5'd16));
        for (int i = 0; i < mbpus_pkg::CFG_LANES - 1; i++) begin
            dir_rows.push_back(beat_row(8'hFF, 0, 0, no_res));
        end
        dir_rows.push_back(beat_row(8'hFF, 1, 1,
                                    make_result(mbpus_pkg::ST_UNIQUE, '0, OFS_W'(1))));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_setting) begin
                wait_drained();
                load_setting(dir_rows[r].pl, dir_rows[r].ph, dir_rows[r].ml,
                             dir_rows[r].mh, dir_rows[r].len);
            end else begin
                send_beat(dir_rows[r].data, dir_rows[r].last, dir_rows[r].typed,
                          dir_rows[r].want);
            end
        end

        // Random phases: each one drains the pipe fully, then loads a new setting
        rand_start = beats_sent;
        while (beats_sent - rand_start < RAND_BEATS) begin
            wait_drained();
            if (beats_sent - rand_start >= RAND_BEATS * 85 / 100) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 10;
                    default: gap_pct = 35;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end

            // pick a setting; lanes past the length carry arbitrary bytes
            case ($urandom_range(0, 9))
                0:       len = 5'd1;
                1:       len = 5'd16;
                default: len = 5'($urandom_range(1, mbpus_pkg::CFG_LANES));
            endcase
            for (int i = 0; i < mbpus_pkg::CFG_LANES; i++) begin
                plane[i] = 8'($urandom_range(0, 255));
                if (i < len) begin
                    mlane[i] = ($urandom_range(0, 99) < 60) ? mbpus_pkg::MASK_COMPARE
                                                            : mbpus_pkg::MASK_IGNORE;
                end else begin
                    mlane[i] = 8'($urandom_range(0, 255));
                end
            end
            mlane[$urandom_range(0, len - 1)] = mbpus_pkg::MASK_COMPARE;
            mode = $urandom_range(0, 9);
            if (mode == 0) begin
                len = '0;
            end else if (mode == 1) begin
                mlane[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
            end else if (mode == 2) begin
                for (int i = 0; i < len; i++) mlane[i] = mbpus_pkg::MASK_IGNORE;
            end
            for (int i = 0; i < mbpus_pkg::LANES_PER_WORD; i++) begin
                pl[8*i +: 8] = plane[i];
                ph[8*i +: 8] = plane[mbpus_pkg::LANES_PER_WORD + i];
                ml[8*i +: 8] = mlane[i];
                mh[8*i +: 8] = mlane[mbpus_pkg::LANES_PER_WORD + i];
            end
            load_setting(pl, ph, ml, mh, len);

            // haystacks built from pattern copies, near misses and noise
            phase_bytes = 0;
            while (phase_bytes < 60) begin
                hay.delete();
                nseg = $urandom_range(0, 4);
                for (int s = 0; s < nseg; s++) begin
                    case ($urandom_range(0, 3))
                        0, 1: begin
                            for (int i = 0; i < len; i++)
                                hay.push_back(mlane[i] == mbpus_pkg::MASK_COMPARE ? plane[i]
                                                                                  : 8'($urandom));
                        end
                        2: begin
                            pos = hay.size();
                            for (int i = 0; i < len; i++)
                                hay.push_back(mlane[i] == mbpus_pkg::MASK_COMPARE ? plane[i]
                                                                                  : 8'($urandom));
                            if (len != 0)
                                hay[pos + $urandom_range(0, len - 1)] ^=
                                    8'($urandom_range(1, 255));
                        end
                        default: begin
                            repeat ($urandom_range(1, 5))
                                hay.push_back($urandom_range(0, 1) ?
                                              plane[$urandom_range(0, mbpus_pkg::CFG_LANES - 1)]
                                              : 8'($urandom));
                        end
                    endcase
                end
                if (hay.size() == 0) hay.push_back(8'($urandom));
                foreach (hay[j]) begin
                    send_beat(hay[j], j == hay.size() - 1, 0, no_res);
                end
                phase_bytes += hay.size();
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (result_q.size() != 0)
            report_mismatch("results never delivered, count", 0, result_q.size());

        $display("Scanned %0d bytes in %0d haystacks under %0d pattern settings",
                 beats_sent, hays_sent, settings_loaded);
        $display("Results seen: unique %0d, not found %0d, ambiguous %0d, invalid %0d",
                 status_seen[mbpus_pkg::ST_UNIQUE], status_seen[mbpus_pkg::ST_NOT_FOUND],
                 status_seen[mbpus_pkg::ST_AMBIGUOUS], status_seen[mbpus_pkg::ST_INVALID]);
        if (err_count == 0) begin
            $display("tb_masked_byte_pattern_unique_search OK");
        end else begin
            $display("tb_masked_byte_pattern_unique_search NOT OK");
        end
        $finish;
    end

endmodule

// File: files.f
sv/mbpus_pkg.sv
sv/mbpus_cell.sv
sv/mbpus_check.sv
sv/masked_byte_pattern_unique_search.sv
dv/tb_masked_byte_pattern_unique_search.sv
